>>> hdl/tsps_pkg.sv
package tsps_pkg;

    // Number of sensors polled in one round.
    localparam int NUM_SENSORS = 4;

    // Index, count and data widths; most follow from the sensor count.
    localparam int IDX_W  = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
    localparam int CNT_W  = $clog2(NUM_SENSORS + 1);
    localparam int RD_W   = 12;
    localparam int SUM_W  = RD_W + $clog2(NUM_SENSORS);
    // A reading LSB is 1/16 C; the average is given in 1/256 C.
    localparam int FRAC_SHIFT = 4;
    localparam int DIV_W  = SUM_W + FRAC_SHIFT;

    // Divisor of the average, kept signed so that the quotient truncates
    // toward zero.
    localparam logic signed [DIV_W-1:0] SENSOR_DIV = DIV_W'(NUM_SENSORS);

    // Fixed field widths.
    localparam int CMD_W      = 2;
    localparam int XS_W       = 2;
    localparam int BYTE_W     = 8;
    localparam int MSG_W      = 2;
    localparam int AVG_W      = 16;
    localparam int TOTAL_W    = 32;
    localparam int PROC_W     = 8;
    localparam int RAMP_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // Commands.
    localparam logic [CMD_W-1:0] CMD_START = 2'd0;
    localparam logic [CMD_W-1:0] CMD_XFER  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WDOG  = 2'd2;

    // Transfer status codes.
    localparam logic [XS_W-1:0] XS_COMPLETE = 2'd0;
    localparam logic [XS_W-1:0] XS_NAK      = 2'd1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TEST_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WD_MIN    = 1'd1;

    localparam logic [PROC_W-1:0]        WD_MIN_RESET = 8'd8;
    localparam logic [PROC_W-1:0]        PROC_MAX     = 8'd255;
    localparam logic signed [RAMP_W-1:0] RAMP_RESET   = -8'sd41;
    localparam logic signed [RAMP_W-1:0] RAMP_TOP     = 8'sd60;
    localparam logic signed [RAMP_W-1:0] RAMP_BOTTOM  = -8'sd40;

    typedef logic signed [RD_W-1:0]  t_reading;
    typedef logic signed [SUM_W-1:0] t_sum;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [XS_W-1:0]   xfer_status;
        logic [BYTE_W-1:0] rx_high;
        logic [BYTE_W-1:0] rx_low;
    } t_in_item;

    typedef struct packed {
        logic                    start_msg;
        logic [MSG_W-1:0]        msg_index;
        logic                    repeat_start;
        logic                    stop_cond;
        logic                    bus_reset;
        logic                    avg_valid;
        logic signed [AVG_W-1:0] avg_temp;
        logic [TOTAL_W-1:0]      reset_total;
    } t_out_item;

    typedef struct packed {
        logic                    start;
        logic signed [DIV_W-1:0] dividend;
    } t_div_req;

    typedef struct packed {
        logic                    done;
        logic signed [AVG_W-1:0] quotient;
    } t_div_rsp;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SUM,
        S_DIV,
        S_DONE
    } t_state;

endpackage

>>> hdl/tsps_in_if.sv
interface tsps_in_if import tsps_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hdl/tsps_out_if.sv
interface tsps_out_if import tsps_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hdl/tsps_ram.sv
module tsps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

>>> hdl/tsps_div.sv
module tsps_div import tsps_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    // The dividend is divided by the sensor count (a power of two) with a
    // signed divide; the quotient truncates toward zero and is ready, with
    // done, in the cycle after the start.
    logic                    r_done;
    logic signed [AVG_W-1:0] r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_req.start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quot <= AVG_W'($signed(i_req.dividend) / SENSOR_DIV);
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quot;

endmodule

>>> hdl/temp_sensor_poll_sequencer.sv
// Channel   Modport   Beat carries
// i_in      sink      cmd, xfer_status, rx_high, rx_low
// o_out     source    start_msg, msg_index, repeat_start, stop_cond, bus_reset,
//                     avg_valid, avg_temp, reset_total
// i_cfg_*   write     register index, write data (test_mode, watchdog_min_count)
//
// Every input beat yields exactly one output beat. Most beats pass through
// the result register and S_DONE into the output register; back-pressure
// holds the block in S_DONE, and no new beat is taken until it is back in
// S_IDLE. A read that closes a round goes through one read of the reading
// RAM per sensor, the last read data, the hand-off of the sum to the
// divider, the registered divide by the sensor count and the output load.
// Reset is synchronous and active low; the reading store is cleared at once
// by per-entry valid bits, so no clearing pass is needed.
// The output register lets the next input beat be taken while a result is
// still waiting downstream.
module temp_sensor_poll_sequencer import tsps_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tsps_in_if.sink               i_in,
    tsps_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Control and sequencing state.
    t_state                    r_state,     n_state;
    logic                      r_test_mode, n_test_mode;
    logic [PROC_W-1:0]         r_wd_min,    n_wd_min;
    logic [IDX_W-1:0]          r_cur,       n_cur;
    logic                      r_retry,     n_retry;
    logic [PROC_W-1:0]         r_proc,      n_proc;
    logic [TOTAL_W-1:0]        r_brst_cnt,  n_brst_cnt;
    logic [CNT_W-1:0]          r_reads,     n_reads;
    logic [NUM_SENSORS-1:0]    r_valid,     n_valid;
    logic signed [RAMP_W-1:0]  r_ramp,      n_ramp;
    logic                      r_rising,    n_rising;
    logic [CNT_W-1:0]          r_cnt,       n_cnt;
    logic                      r_pend,      n_pend;
    logic                      r_out_vld,   n_out_vld;

    // Payload registers.
    logic                      r_pend_ok,   n_pend_ok;
    t_sum                      r_acc,       n_acc;
    t_out_item                 r_res,       n_res;
    t_out_item                 r_out,       n_out;

    // Reading RAM and divider connections.
    logic                      ram_we;
    logic [IDX_W-1:0]          ram_waddr;
    logic [RD_W-1:0]           ram_wdata;
    logic [IDX_W-1:0]          ram_raddr;
    logic [RD_W-1:0]           ram_rdata;
    t_div_req                  div_req;
    t_div_rsp                  div_rsp;

    function automatic logic [MSG_W-1:0] f_msg(input logic [IDX_W-1:0] idx);
        logic [31:0] wide;
        wide = 32'(idx);
        return wide[MSG_W-1:0];
    endfunction

    tsps_ram #(
        .WIDTH (RD_W),
        .DEPTH (NUM_SENSORS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    tsps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        logic                     advance;
        logic                     go_sum;
        logic                     issue;
        logic signed [RAMP_W-1:0] ramp_nx;
        logic [15:0]              raw;

        n_state     = r_state;
        n_test_mode = r_test_mode;
        n_wd_min    = r_wd_min;
        n_cur       = r_cur;
        n_retry     = r_retry;
        n_proc      = r_proc;
        n_brst_cnt  = r_brst_cnt;
        n_reads     = r_reads;
        n_valid     = r_valid;
        n_ramp      = r_ramp;
        n_rising    = r_rising;
        n_cnt       = r_cnt;
        n_pend      = 1'b0;
        n_pend_ok   = 1'b0;
        n_acc       = r_acc;
        n_res       = r_res;
        n_out       = r_out;
        n_out_vld   = r_out_vld && !o_out.ready;

        advance   = 1'b0;
        go_sum    = 1'b0;
        issue     = 1'b0;
        ramp_nx   = r_ramp;
        raw       = {i_in.data.rx_high, i_in.data.rx_low};

        ram_we    = 1'b0;
        ram_waddr = r_cur;
        // The sensor register is big-endian; its top twelve bits are the
        // signed reading.
        ram_wdata = raw[15:16-RD_W];
        ram_raddr = r_cnt[IDX_W-1:0];

        div_req.start    = 1'b0;
        div_req.dividend = {r_acc, {FRAC_SHIFT{1'b0}}};

        // The user must write configuration only while the block is idle; the block itself does not enforce this.
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TEST_MODE: n_test_mode = i_cfg_data[0];
                CFG_WD_MIN:    n_wd_min    = i_cfg_data;
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_res             = '0;
                    n_res.msg_index   = f_msg(r_cur);
                    n_res.reset_total = r_brst_cnt;
                    case (i_in.data.cmd)
                        CMD_START: begin
                            // Starts the round at message 0 without moving
                            // the current index.
                            n_res.start_msg = 1'b1;
                            n_res.msg_index = '0;
                        end
                        CMD_XFER: begin
                            advance = 1'b1;
                            case (i_in.data.xfer_status)
                                XS_COMPLETE: begin
                                    ram_we         = 1'b1;
                                    n_valid[r_cur] = 1'b1;
                                    if (r_test_mode) begin
                                        // The triangle ramp turns round at
                                        // its top and bottom values.
                                        if (r_rising) begin
                                            ramp_nx = r_ramp + 8'sd1;
                                            if (ramp_nx >= RAMP_TOP) begin
                                                n_rising = 1'b0;
                                            end
                                        end else begin
                                            ramp_nx = r_ramp - 8'sd1;
                                            if (ramp_nx <= RAMP_BOTTOM) begin
                                                n_rising = 1'b1;
                                            end
                                        end
                                        n_ramp          = ramp_nx;
                                        n_res.avg_valid = 1'b1;
                                        n_res.avg_temp  = {ramp_nx, 8'b0};
                                    end else if (r_reads >= CNT_W'(NUM_SENSORS - 1)) begin
                                        // Last read of a round: sum the
                                        // stored readings, then average.
                                        n_reads = '0;
                                        go_sum  = 1'b1;
                                    end else begin
                                        n_reads = r_reads + CNT_W'(1);
                                    end
                                end
                                XS_NAK: begin
                                    if (!r_retry) begin
                                        // First refusal retries the same
                                        // message.
                                        n_retry            = 1'b1;
                                        n_res.repeat_start = 1'b1;
                                        advance            = 1'b0;
                                    end else begin
                                        n_retry         = 1'b0;
                                        n_res.stop_cond = 1'b1;
                                    end
                                end
                                default: ;
                            endcase
                            if (advance) begin
                                if (r_cur == IDX_W'(NUM_SENSORS - 1)) begin
                                    n_cur           = '0;
                                    n_res.msg_index = '0;
                                end else begin
                                    n_cur           = r_cur + IDX_W'(1);
                                    n_res.start_msg = 1'b1;
                                    n_res.msg_index = f_msg(r_cur + IDX_W'(1));
                                end
                                if (r_proc != PROC_MAX) begin
                                    n_proc = r_proc + PROC_W'(1);
                                end
                            end
                        end
                        CMD_WDOG: begin
                            // Too little bus traffic since the last tick
                            // asks for a bus controller reset.
                            if (r_proc <= r_wd_min) begin
                                n_res.bus_reset   = 1'b1;
                                n_brst_cnt        = r_brst_cnt + TOTAL_W'(1);
                                n_res.reset_total = r_brst_cnt + TOTAL_W'(1);
                            end
                            n_proc = '0;
                        end
                        default: ;
                    endcase
                    if (go_sum) begin
                        n_cnt   = '0;
                        n_acc   = '0;
                        n_state = S_SUM;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SUM: begin
                // One RAM read issued per cycle; the read data is registered and returns in the next cycle.
                // Entries never written since reset count as zero.
                issue = (r_cnt < CNT_W'(NUM_SENSORS));
                if (issue) begin
                    n_pend    = 1'b1;
                    n_pend_ok = r_valid[r_cnt[IDX_W-1:0]];
                    n_cnt     = r_cnt + CNT_W'(1);
                end
                if (r_pend && r_pend_ok) begin
                    n_acc = r_acc + SUM_W'(t_reading'(ram_rdata));
                end
                if (!issue && !r_pend) begin
                    div_req.start = 1'b1;
                    n_state       = S_DIV;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_res.avg_valid = 1'b1;
                    n_res.avg_temp  = div_rsp.quotient;
                    n_state         = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_vld || o_out.ready) begin
                    n_out_vld = 1'b1;
                    n_out     = r_res;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_test_mode <= 1'b0;
            r_wd_min    <= WD_MIN_RESET;
            r_cur       <= '0;
            r_retry     <= 1'b0;
            r_proc      <= '0;
            r_brst_cnt  <= '0;
            r_reads     <= '0;
            r_valid     <= '0;
            r_ramp      <= RAMP_RESET;
            r_rising    <= 1'b1;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_test_mode <= n_test_mode;
            r_wd_min    <= n_wd_min;
            r_cur       <= n_cur;
            r_retry     <= n_retry;
            r_proc      <= n_proc;
            r_brst_cnt  <= n_brst_cnt;
            r_reads     <= n_reads;
            r_valid     <= n_valid;
            r_ramp      <= n_ramp;
            r_rising    <= n_rising;
            r_cnt       <= n_cnt;
            r_pend      <= n_pend;
            r_out_vld   <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_ok <= n_pend_ok;
        r_acc     <= n_acc;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

endmodule

>>> tb/tb_top.sv
`default_nettype none

// Self-checking bench for the temperature sensor poll sequencer. Every beat
// accepted on the input channel is run through a cycle-free copy of the
// sequencer kept in this module, and the report it yields is queued unless
// the table gives one by hand. Each beat leaving the output channel is
// checked, field by field, against the oldest queued report.
module tb_top;
    import tsps_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Codes that the package leaves without a name.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [XS_W-1:0]  XS_OTHER   = 2'd2;
    localparam logic [XS_W-1:0]  XS_UNUSED  = 2'd3;

    localparam int SHOWN_MISMATCHES = 10;

    // One line of the directed table: either a register write or an input
    // beat, the latter optionally with its report written out by hand.
    typedef struct packed {
        logic                  is_reg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        t_in_item              beat;
        logic                  typed;
        t_out_item             want;
    } t_row;

    // Settings and traffic shape of one random phase.
    typedef struct {
        int idle_pct;
        int stall_pct;
        bit ramp_on;
        int wd_floor;
        int beats;
        bit no_ticks;
    } t_phase;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    tsps_in_if  in_ch ();
    tsps_out_if out_ch ();

    temp_sensor_poll_sequencer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow of the sequencer. It starts in the state that reset leaves
    // behind, and the register copies follow every write the bench makes.
    bit          mode_test   = 1'b0;
    int          wd_floor    = int'(WD_MIN_RESET);
    int          seq_index   = 0;
    bit          nak_seen    = 1'b0;
    int          xfer_count  = 0;
    logic [TOTAL_W-1:0] resets_seen = '0;
    int          round_reads = 0;
    int          readings[NUM_SENSORS] = '{default: 0};
    int          ramp_deg    = int'(RAMP_RESET);
    bit          ramp_up     = 1'b1;

    // Reports still owed by the block, oldest first.
    t_out_item   reports_due[$];

    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    int          mismatches    = 0;
    int          beats_checked = 0;
    int          temps_seen    = 0;

    // Works out the report for one accepted beat and moves the shadow state.
    function automatic t_out_item compute_report(input t_in_item b);
        t_out_item  r;
        logic       advance;
        logic [15:0] word;
        t_reading   rd;
        int         total;
        r = '0;
        r.msg_index = MSG_W'(seq_index);
        case (b.cmd)
            CMD_START: begin
                // The round restarts at message 0, but the position held
                // inside the block is left where it was.
                r.start_msg = 1'b1;
                r.msg_index = '0;
            end
            CMD_XFER: begin
                advance = 1'b1;
                if (b.xfer_status == XS_COMPLETE) begin
                    word = {b.rx_high, b.rx_low};
                    rd = t_reading'(word[15:4]);
                    if (seq_index < NUM_SENSORS) begin
                        readings[seq_index] = int'(rd);
                    end
                    if (mode_test) begin
                        // The ramp turns round at its top and bottom.
                        if (ramp_up) begin
                            ramp_deg++;
                            if (ramp_deg >= int'(RAMP_TOP)) ramp_up = 1'b0;
                        end else begin
                            ramp_deg--;
                            if (ramp_deg <= int'(RAMP_BOTTOM)) ramp_up = 1'b1;
                        end
                        r.avg_temp  = AVG_W'(ramp_deg * 256);
                        r.avg_valid = 1'b1;
                    end else begin
                        round_reads++;
                        if (round_reads >= NUM_SENSORS) begin
                            round_reads = 0;
                            total = 0;
                            foreach (readings[k]) total += readings[k];
                            // Readings are in 1/16 C; the average is in 1/256 C.
                            r.avg_temp  = AVG_W'((total * 16) / NUM_SENSORS);
                            r.avg_valid = 1'b1;
                        end
                    end
                end else if (b.xfer_status == XS_NAK) begin
                    // A completed read in between does not clear the retry.
                    if (!nak_seen) begin
                        nak_seen       = 1'b1;
                        r.repeat_start = 1'b1;
                        advance        = 1'b0;
                    end else begin
                        nak_seen    = 1'b0;
                        r.stop_cond = 1'b1;
                    end
                end
                if (advance) begin
                    if (seq_index + 1 < NUM_SENSORS) begin
                        seq_index++;
                        r.start_msg = 1'b1;
                    end else begin
                        seq_index = 0;
                    end
                    r.msg_index = MSG_W'(seq_index);
                    if (xfer_count < int'(PROC_MAX)) xfer_count++;
                end
            end
            CMD_WDOG: begin
                if (xfer_count <= wd_floor) begin
                    r.bus_reset = 1'b1;
                    resets_seen++;
                end
                xfer_count = 0;
            end
            default: begin
            end
        endcase
        r.reset_total = resets_seen;
        return r;
    endfunction

    function automatic string show(input t_out_item r);
        return $sformatf("start=%0b idx=%0d rep=%0b stop=%0b brst=%0b vld=%0b avg=%0d total=%0d",
                         r.start_msg, r.msg_index, r.repeat_start, r.stop_cond,
                         r.bus_reset, r.avg_valid, r.avg_temp, r.reset_total);
    endfunction

    function automatic void note_mismatch(input string what);
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES) $display("ERROR @%0t: %s", $time, what);
    endfunction

    function automatic t_out_item report(input logic start, input int idx, input logic rep,
                                         input logic stp, input logic brst, input logic vld,
                                         input int avg, input int total);
        t_out_item r;
        r.start_msg    = start;
        r.msg_index    = MSG_W'(idx);
        r.repeat_start = rep;
        r.stop_cond    = stp;
        r.bus_reset    = brst;
        r.avg_valid    = vld;
        r.avg_temp     = AVG_W'(avg);
        r.reset_total  = TOTAL_W'(total);
        return r;
    endfunction

    function automatic t_row beat_row(input logic [CMD_W-1:0] c, input logic [XS_W-1:0] s,
                                      input logic [BYTE_W-1:0] hi, input logic [BYTE_W-1:0] lo);
        t_row r;
        r = '0;
        r.beat.cmd         = c;
        r.beat.xfer_status = s;
        r.beat.rx_high     = hi;
        r.beat.rx_low      = lo;
        return r;
    endfunction

    function automatic t_row typed_row(input logic [CMD_W-1:0] c, input logic [XS_W-1:0] s,
                                       input t_out_item want);
        t_row r;
        r = beat_row(c, s, 8'hff, 8'hff);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic t_row reg_row(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] val);
        t_row r;
        r = '0;
        r.is_reg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    // Random traffic: mostly transfer-done events, with completed reads the
    // common case, and now and then a restart, a watchdog tick or an unused
    // command. With ticks held back the count of processed transfers can
    // climb to saturation.
    function automatic t_in_item random_beat(input bit no_ticks);
        t_in_item b;
        int       pick;
        pick = $urandom_range(99);
        if (pick < 7) b.cmd = CMD_START;
        else if (pick < 84 || (no_ticks && pick < 97)) b.cmd = CMD_XFER;
        else if (pick < 97) b.cmd = CMD_WDOG;
        else b.cmd = CMD_UNUSED;
        pick = $urandom_range(99);
        if (pick < 80) b.xfer_status = XS_COMPLETE;
        else if (pick < 92) b.xfer_status = XS_NAK;
        else if (pick < 97) b.xfer_status = XS_OTHER;
        else b.xfer_status = XS_UNUSED;
        b.rx_high = BYTE_W'($urandom);
        b.rx_low  = BYTE_W'($urandom);
        return b;
    endfunction

    // Offers one beat after a random number of idle cycles and waits for the
    // handshake. Valid is left high so that a following beat can go out
    // back to back; each falling edge sees one assignment to valid at most.
    task automatic drive_beat(input t_in_item b, input bit typed, input t_out_item want);
        t_out_item predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.data  <= b;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        predicted = compute_report(b);
        reports_due.push_back(typed ? want : predicted);
    endtask

    // Holds the sender back until every owed report has come out, so that
    // the block is idle and a register may be written.
    task automatic wait_idle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (reports_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        if (idx == CFG_TEST_MODE) mode_test = val[0];
        else if (idx == CFG_WD_MIN) wd_floor = int'(val);
    endtask

    // Back-pressure on the output: ready is redrawn on every falling edge.
    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Output side: every beat taken from the block is checked against the
    // oldest report still owed.
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        string     diff;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            got = out_ch.data;
            beats_checked++;
            if (got.avg_valid === 1'b1) temps_seen++;
            if (reports_due.size() == 0) begin
                note_mismatch($sformatf("report with none owed: %s", show(got)));
            end else begin
                want = reports_due.pop_front();
                diff = "";
                if (got.start_msg !== want.start_msg) diff = {diff, " start_msg"};
                if (got.msg_index !== want.msg_index) diff = {diff, " msg_index"};
                if (got.repeat_start !== want.repeat_start) diff = {diff, " repeat_start"};
                if (got.stop_cond !== want.stop_cond) diff = {diff, " stop_cond"};
                if (got.bus_reset !== want.bus_reset) diff = {diff, " bus_reset"};
                if (got.avg_valid !== want.avg_valid) diff = {diff, " avg_valid"};
                if (got.avg_temp !== want.avg_temp) diff = {diff, " avg_temp"};
                if (got.reset_total !== want.reset_total) diff = {diff, " reset_total"};
                if (diff != "") begin
                    note_mismatch($sformatf("report %0d differs in%s\n  expected %s\n  actual   %s",
                                            beats_checked, diff, show(want), show(got)));
                end
            end
        end
    end

    initial begin
        t_row     plan[$];
        t_phase   phases[5];
        t_phase   ph;
        t_in_item tick;
        int       n;
        int       extra;

        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = '0;
        cfg_data     = '0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;

        // Directed part. The first three reports follow straight from the
        // reset state and are written out; the rest come from the shadow.
        plan = '{
            // Unused command straight after reset: nothing happens.
            typed_row(CMD_UNUSED, XS_UNUSED, report(0, 0, 0, 0, 0, 0, 0, 0)),
            // Nothing processed yet, so the first tick asks for a bus reset.
            typed_row(CMD_WDOG, XS_COMPLETE, report(0, 0, 0, 0, 1, 0, 0, 1)),
            typed_row(CMD_START, XS_COMPLETE, report(1, 0, 0, 0, 0, 0, 0, 1)),
            // Highest and lowest readings the sensor can give.
            beat_row(CMD_XFER, XS_COMPLETE, 8'h7f, 8'hf0),
            beat_row(CMD_XFER, XS_COMPLETE, 8'h80, 8'h00),
            // A restart in mid-round asks for message 0 but keeps the place.
            beat_row(CMD_START, XS_NAK, 8'h00, 8'h00),
            // First NAK retries in place, the second gives up and moves on.
            beat_row(CMD_XFER, XS_NAK, 8'h00, 8'h00),
            beat_row(CMD_XFER, XS_NAK, 8'h00, 8'h00),
            beat_row(CMD_XFER, XS_OTHER, 8'h55, 8'haa),
            beat_row(CMD_XFER, XS_UNUSED, 8'haa, 8'h55),
            // Low nibble of the second byte is dropped; the second of these
            // reads closes a round.
            beat_row(CMD_XFER, XS_COMPLETE, 8'h7f, 8'hff),
            beat_row(CMD_XFER, XS_COMPLETE, 8'hff, 8'hff),
            // A round of top readings, then a round of bottom readings.
            beat_row(CMD_XFER, XS_COMPLETE, 8'h7f, 8'hf0),
            beat_row(CMD_XFER, XS_COMPLETE, 8'h7f, 8'hf0),
            beat_row(CMD_XFER, XS_COMPLETE, 8'h7f, 8'hf0),
            beat_row(CMD_XFER, XS_COMPLETE, 8'h7f, 8'hf0),
            beat_row(CMD_XFER, XS_COMPLETE, 8'h80, 8'h00),
            beat_row(CMD_XFER, XS_COMPLETE, 8'h80, 8'h00),
            beat_row(CMD_XFER, XS_COMPLETE, 8'h80, 8'h00),
            beat_row(CMD_XFER, XS_COMPLETE, 8'h80, 8'h00),
            // A good read between two NAKs leaves the retry armed.
            beat_row(CMD_XFER, XS_NAK, 8'h00, 8'h00),
            beat_row(CMD_XFER, XS_COMPLETE, 8'h00, 8'h00),
            beat_row(CMD_XFER, XS_NAK, 8'h00, 8'h00),
            // Plenty of transfers since the last tick: no bus reset.
            beat_row(CMD_WDOG, XS_UNUSED, 8'hff, 8'hff),
            // Test mode: the first read gives the bottom of the ramp.
            reg_row(CFG_TEST_MODE, 8'd1),
            beat_row(CMD_XFER, XS_COMPLETE, 8'h12, 8'h34)
        };

        // Random phases: no idling, a slow sender, a long run against a
        // stalling receiver without watchdog ticks so that the transfer
        // count saturates and the ramp turns at both ends, both sides idling
        // now and then, then no idling at the reset watchdog minimum.
        phases[0] = '{0, 0, 1'b0, 255, 30, 1'b0};
        phases[1] = '{73, 0, 1'b1, 0, 30, 1'b0};
        phases[2] = '{0, 73, 1'b1, 254, 200, 1'b1};
        phases[3] = '{20, 20, 1'b0, int'($urandom_range(1, 254)), 30, 1'b0};
        phases[4] = '{0, 0, 1'b0, int'(WD_MIN_RESET), 30, 1'b0};

        tick = '{cmd: CMD_WDOG, xfer_status: XS_COMPLETE, rx_high: 8'h00, rx_low: 8'h00};

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) begin
            if (plan[k].is_reg) begin
                wait_idle();
                write_reg(plan[k].reg_idx, plan[k].reg_val);
            end else begin
                drive_beat(plan[k].beat, plan[k].typed, plan[k].want);
            end
        end

        foreach (phases[p]) begin
            ph = phases[p];
            wait_idle();
            // Upper data bits of the mode register are don't-care.
            write_reg(CFG_TEST_MODE, {7'($urandom), ph.ramp_on});
            write_reg(CFG_WD_MIN, CFG_DATA_W'(ph.wd_floor));
            send_idle_pct = ph.idle_pct;
            stall_pct     = ph.stall_pct;
            n     = 0;
            extra = 0;
            // Without ticks the phase runs on until the transfer count has
            // sat at its ceiling for a few more beats.
            while (n < ph.beats || (ph.no_ticks && extra < 8)) begin
                drive_beat(random_beat(ph.no_ticks), 1'b0, '0);
                n++;
                if (ph.no_ticks && xfer_count == int'(PROC_MAX)) extra++;
            end
            if (ph.no_ticks) begin
                drive_beat(tick, 1'b0, '0);
            end
        end

        // Drain, then keep the clock running so that any stray beat would show
        // before the final count.
        wait_idle();
        repeat (40) @(posedge i_clk);
        if (reports_due.size() != 0) begin
            note_mismatch($sformatf("%0d reports never arrived", reports_due.size()));
        end

        $display("Checked %0d report beats over the directed table and %0d random phases.",
                 beats_checked, $size(phases));
        $display("%0d beats carried an average or ramp value; %0d bus resets were requested.",
                 temps_seen, resets_seen);
        if (mismatches == 0) begin
            $display("temp_sensor_poll_sequencer: match");
        end else begin
            $display("temp_sensor_poll_sequencer: mismatch");
        end
        $finish;
    end

    // Watchdog on the bench itself: far beyond the slowest correct run.
    initial begin
        #(5_000_000);
        $display("ERROR: run timed out with %0d reports owed", reports_due.size());
        $display("temp_sensor_poll_sequencer: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
